// File: design/gmps_pkg.sv
// Shared types, codes and width helpers for the grid path-sum block.
package gmps_pkg;

    // Default grid capacity
    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 32;

    // Fixed field widths
    localparam int CFG_W  = 6;
    localparam int IDX_W  = 1;
    localparam int CELL_W = 16;
    localparam int SUM_W  = 32;
    localparam int OUT_W  = 40;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [IDX_W-1:0] REG_GRID_COLS = 1'b1;

    // Result kinds
    localparam logic KIND_TOTAL = 1'b0;
    localparam logic KIND_MOVE  = 1'b1;

    // Move directions
    localparam logic DIR_RIGHT = 1'b0;
    localparam logic DIR_DOWN  = 1'b1;

    typedef enum logic [2:0] {
        S_CELL,
        S_TOTAL,
        S_READ,
        S_STEP,
        S_MOVE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic cell_go;
        logic trace_step;
        logic move_pop;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cell_last;
        logic one_cell;
        logic trace_end;
        logic move_end;
    } t_stat;

    // Index width for a store of n entries, at least one bit
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// File: design/grid_max_path_sum.sv
// Top level of the streaming grid maximum path-sum engine.
//
//  channel   | direction | words
//  s_axis    | in        | one grid cell value per word, row-major
//  m_axis    | out       | total word, then one word per move, tlast on the final one
//  cfg       | in        | grid_rows (index 0), grid_cols (index 1)
//
// One cell word is taken per cycle; s_axis_tready stays high while a grid's cells
// come in and is low while its results go out. After the last cell: the total word,
// then the traceback, with a read state and a step state per move for the registered
// read of the direction memory, then one word per move, before the next grid.
// Reset is synchronous; no clearing pass is needed. Stalls on m_axis hold the word.
module grid_max_path_sum
    import gmps_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [CELL_W-1:0]  i_s_axis_tdata,   // [15:0] cell_value
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [OUT_W-1:0]   o_m_axis_tdata,   // [31:0] path_total, [32] move_dir, zero above
    output logic               o_m_axis_tuser,   // [0] result_kind
    output logic               o_m_axis_tlast    // last_result
);

    t_cmd                    cmd;
    t_stat                   stat;
    logic                    out_kind;
    logic signed [SUM_W-1:0] total;
    logic                    move;

    gmps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_kind  (out_kind),
        .o_out_last  (o_m_axis_tlast),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    gmps_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cell_value (i_s_axis_tdata),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_total      (total),
        .o_move       (move)
    );

    // Pack the result word; unused field reads zero
    always_comb begin
        o_m_axis_tuser = out_kind;
        o_m_axis_tdata = '0;
        if (out_kind == KIND_TOTAL) begin
            o_m_axis_tdata[SUM_W-1:0] = total;
        end else begin
            o_m_axis_tdata[SUM_W] = move;
        end
    end

endmodule

// File: design/gmps_ctrl.sv
// Sequencer for cell intake, total, traceback and move output.
module gmps_ctrl
    import gmps_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output logic  o_out_kind,
    output logic  o_out_last,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CELL;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_kind  = KIND_TOTAL;
        o_out_last  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_CELL: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cell_go = 1'b1;
                    if (i_stat.cell_last) begin
                        n_state = S_TOTAL;
                    end
                end
            end
            S_TOTAL: begin
                o_out_valid = 1'b1;
                o_out_kind  = KIND_TOTAL;
                o_out_last  = i_stat.one_cell;
                if (i_out_ready) begin
                    n_state = i_stat.one_cell ? S_CELL : S_READ;
                end
            end
            S_READ: begin
                // direction bit is fetched this cycle
                n_state = S_STEP;
            end
            S_STEP: begin
                o_cmd.trace_step = 1'b1;
                n_state = i_stat.trace_end ? S_MOVE : S_READ;
            end
            S_MOVE: begin
                o_out_valid = 1'b1;
                o_out_kind  = KIND_MOVE;
                o_out_last  = i_stat.move_end;
                if (i_out_ready) begin
                    o_cmd.move_pop = 1'b1;
                    if (i_stat.move_end) begin
                        n_state = S_CELL;
                    end
                end
            end
            default: begin
                n_state = S_CELL;
            end
        endcase
    end

endmodule

// File: design/gmps_dp.sv
// Datapath: row sums, direction memory, traceback position and move stack.
module gmps_dp
    import gmps_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_wdata,
    input  logic signed [CELL_W-1:0] i_cell_value,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    output logic signed [SUM_W-1:0]  o_total,
    output logic                     o_move
);

    localparam int RW   = idx_w(MAX_ROWS);
    localparam int CW   = idx_w(MAX_COLS);
    localparam int AW   = idx_w(MAX_ROWS * MAX_COLS);
    localparam int SW   = MAX_ROWS + MAX_COLS;
    localparam int CNTW = $clog2(SW + 1);
    localparam logic [CFG_W-1:0] ROWS_MAX = CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] COLS_MAX = CFG_W'(MAX_COLS);
    localparam logic [AW-1:0]    COLS_K   = AW'(MAX_COLS);
    localparam logic signed [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W-1){1'b0}}};

    logic [CFG_W-1:0]        r_rows_cfg;
    logic [CFG_W-1:0]        r_cols_cfg;
    logic [RW-1:0]           r_row;
    logic [CW-1:0]           r_col;
    logic signed [SUM_W-1:0] r_left;
    logic signed [SUM_W-1:0] r_sums [MAX_COLS];
    logic                    r_dir_mem [MAX_ROWS * MAX_COLS];
    logic                    r_dir_rd;
    logic [RW-1:0]           r_ti;
    logic [CW-1:0]           r_tj;
    logic [SW-1:0]           r_stack;
    logic [CNTW-1:0]         r_cnt;

    logic [CFG_W-1:0]        rows_eff;
    logic [CFG_W-1:0]        cols_eff;
    logic [RW-1:0]           row_e;
    logic [CW-1:0]           col_e;
    logic                    row_last;
    logic                    col_last;
    logic signed [SUM_W-1:0] above;
    logic                    use_left;
    logic signed [SUM_W-1:0] addend;
    logic signed [SUM_W:0]   wide_sum;
    logic signed [SUM_W-1:0] sum;
    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           rd_addr;
    logic                    tr_dir;
    logic [RW-1:0]           ti_nxt;
    logic [CW-1:0]           tj_nxt;

    // Clamp sizes to 1..max
    always_comb begin
        rows_eff = (r_rows_cfg == '0) ? CFG_W'(1) :
                   (r_rows_cfg > ROWS_MAX) ? ROWS_MAX : r_rows_cfg;
        cols_eff = (r_cols_cfg == '0) ? CFG_W'(1) :
                   (r_cols_cfg > COLS_MAX) ? COLS_MAX : r_cols_cfg;
    end

    // Effective position: fold back to top-left when outside the grid
    always_comb begin
        if (CFG_W'(r_row) >= rows_eff || CFG_W'(r_col) >= cols_eff) begin
            row_e = '0;
            col_e = '0;
        end else begin
            row_e = r_row;
            col_e = r_col;
        end
        row_last = (CFG_W'(row_e) + CFG_W'(1)) == rows_eff;
        col_last = (CFG_W'(col_e) + CFG_W'(1)) == cols_eff;
    end

    // Pick the better neighbor; ties go to the cell above
    always_comb begin
        above    = r_sums[col_e];
        use_left = (row_e == '0) || ((col_e != '0) && (above < r_left));
        if (row_e == '0 && col_e == '0) begin
            addend = '0;
        end else if (use_left) begin
            addend = r_left;
        end else begin
            addend = above;
        end
        wide_sum = {addend[SUM_W-1], addend}
                 + {{(SUM_W+1-CELL_W){i_cell_value[CELL_W-1]}}, i_cell_value};
        if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
            sum = wide_sum[SUM_W] ? SUM_LO : SUM_HI;
        end else begin
            sum = wide_sum[SUM_W-1:0];
        end
    end

    // Configuration and cell position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= CFG_W'(1);
            r_cols_cfg <= CFG_W'(1);
            r_row      <= '0;
            r_col      <= '0;
            r_left     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GRID_ROWS: r_rows_cfg <= i_cfg_wdata;
                REG_GRID_COLS: r_cols_cfg <= i_cfg_wdata;
                default: ;
            endcase
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.cell_go) begin
            r_left <= sum;
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : row_e + RW'(1);
            end else begin
                r_col <= col_e + CW'(1);
                r_row <= row_e;
            end
        end
    end

    // Running row of sums
    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_go) begin
            r_sums[col_e] <= sum;
        end
    end

    // Direction memory: one write port, one registered read port
    assign wr_addr = AW'(row_e) * COLS_K + AW'(col_e);
    assign rd_addr = AW'(r_ti) * COLS_K + AW'(r_tj);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_go) begin
            r_dir_mem[wr_addr] <= use_left ? DIR_RIGHT : DIR_DOWN;
        end
        r_dir_rd <= r_dir_mem[rd_addr];
    end

    // Traceback step: edges force the direction
    always_comb begin
        if (r_ti == '0) begin
            tr_dir = DIR_RIGHT;
        end else if (r_tj == '0) begin
            tr_dir = DIR_DOWN;
        end else begin
            tr_dir = r_dir_rd;
        end
        ti_nxt = (tr_dir == DIR_DOWN) ? r_ti - RW'(1) : r_ti;
        tj_nxt = (tr_dir == DIR_DOWN) ? r_tj : r_tj - CW'(1);
    end

    // Trace position and move stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_go && row_last && col_last) begin
            r_ti <= row_e;
            r_tj <= col_e;
        end else if (i_cmd.trace_step) begin
            r_ti <= ti_nxt;
            r_tj <= tj_nxt;
        end
        if (i_cmd.trace_step) begin
            r_stack <= {r_stack[SW-2:0], tr_dir};
        end else if (i_cmd.move_pop) begin
            r_stack <= {1'b0, r_stack[SW-1:1]};
        end
    end

    // Move count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cell_go && row_last && col_last) begin
            r_cnt <= '0;
        end else if (i_cmd.trace_step) begin
            r_cnt <= r_cnt + CNTW'(1);
        end else if (i_cmd.move_pop) begin
            r_cnt <= r_cnt - CNTW'(1);
        end
    end

    // Status back to the sequencer
    always_comb begin
        o_stat.cell_last = row_last && col_last;
        o_stat.one_cell  = (r_ti == '0) && (r_tj == '0);
        o_stat.trace_end = (ti_nxt == '0) && (tj_nxt == '0);
        o_stat.move_end  = r_cnt == CNTW'(1);
    end

    assign o_total = r_left;
    assign o_move  = r_stack[0];

endmodule

// File: design/gmps_check.sv
// Port-level checker for the grid path-sum engine, bound to the top level.
module gmps_check
    import gmps_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tready,
    input logic             i_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] i_m_axis_tdata,
    input logic             i_m_axis_tuser,
    input logic             i_m_axis_tlast
);

    // Intake and result output never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tready |-> !i_m_axis_tvalid)
        else $error("intake open while a result is shown");

    // After the final result the block takes cells again
    a_back_to_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_axis_tvalid && i_m_axis_tready && i_m_axis_tlast) |=> i_s_axis_tready)
        else $error("no return to intake after final result");

    // Unused payload field stays zero for each kind
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |->
            ((i_m_axis_tuser == KIND_MOVE && i_m_axis_tdata[SUM_W-1:0] == '0) ||
             (i_m_axis_tuser == KIND_TOTAL && i_m_axis_tdata[SUM_W] == 1'b0)))
        else $error("unused result field not zero");

    // Stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_axis_tvalid && !i_m_axis_tready) |=>
            (i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser)
             && $stable(i_m_axis_tlast)))
        else $error("stalled result word changed");

endmodule

bind grid_max_path_sum gmps_check u_gmps_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser),
    .i_m_axis_tlast  (o_m_axis_tlast)
);
